// File: src/aarm_pkg.sv
package aarm_pkg;

  // Q30 constants for the angle path
  localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;
  localparam logic signed [33:0] Q30_PI   = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HPI  = 34'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN = 34'sd652032874;

  // Q14 one, also the saturation limit
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  // arctan(2^-i) in Q30, rounded to nearest
  localparam logic [30:0] ATAN_Q30 [32] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128,
    31'd64,        31'd32,        31'd16,        31'd8,
    31'd4,         31'd2,         31'd1,         31'd0
  };

  // item as classified by the front end
  typedef struct packed {
    logic signed [33:0] ang;   // folded angle, Q30
    logic               flip;  // negate cos and sin
    logic               zero;  // axis all zero
    logic [31:0]        n2;    // squared axis length
    logic [2:0][15:0]   mag;   // axis magnitudes
    logic [2:0]         neg;   // axis signs
  } aarm_item_t;

  // item after axis normalization
  typedef struct packed {
    logic signed [33:0] ang;
    logic               flip;
    logic               zero;
    logic [2:0][31:0]   unit;  // unit axis, signed Q30
  } aarm_rot_t;

  // item after cos/sin
  typedef struct packed {
    logic signed [33:0] c;
    logic signed [33:0] s;
    logic               zero;
    logic [2:0][31:0]   unit;
  } aarm_cs_t;

endpackage

// File: src/aarm_front.sv
module aarm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic signed [15:0]   in_angle,
  input  logic signed [15:0]   in_axis_x,
  input  logic signed [15:0]   in_axis_y,
  input  logic signed [15:0]   in_axis_z,
  output logic                 push,
  output aarm_pkg::aarm_item_t push_item
);
  import aarm_pkg::*;

  logic                 f1_vld_r;
  logic signed [33:0]   f1_ang_r, f1_ang_nxt;
  logic                 f1_flip_r, f1_flip_nxt;
  logic                 f1_zero_r;
  logic [2:0][15:0]     f1_mag_r, f1_mag_nxt;
  logic [2:0]           f1_neg_r, f1_neg_nxt;
  logic [2:0][31:0]     f1_sq_r, f1_sq_nxt;
  logic                 f2_vld_r;
  aarm_item_t           f2_item_r;
  logic signed [33:0]   ang_ext;
  logic [2:0][15:0]     axis;

  assign axis = {in_axis_z, in_axis_y, in_axis_x};

  // angle to Q30, fold by pi; axis magnitudes and squares
  always_comb begin
    ang_ext = $signed({in_angle[15], in_angle, 17'b0});
    f1_ang_nxt  = ang_ext;
    f1_flip_nxt = 1'b0;
    if (ang_ext > Q30_HPI) begin
      f1_ang_nxt  = ang_ext - Q30_PI;
      f1_flip_nxt = 1'b1;
    end else if (ang_ext < -Q30_HPI) begin
      f1_ang_nxt  = ang_ext + Q30_PI;
      f1_flip_nxt = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      f1_neg_nxt[j] = axis[j][15];
      f1_mag_nxt[j] = axis[j][15] ? (~axis[j] + 16'd1) : axis[j];
      f1_sq_nxt[j]  = 32'(f1_mag_nxt[j]) * 32'(f1_mag_nxt[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= in_take;
      f2_vld_r <= f1_vld_r;
    end
    f1_ang_r  <= f1_ang_nxt;
    f1_flip_r <= f1_flip_nxt;
    f1_zero_r <= (in_axis_x == 16'sd0) && (in_axis_y == 16'sd0) && (in_axis_z == 16'sd0);
    f1_mag_r  <= f1_mag_nxt;
    f1_neg_r  <= f1_neg_nxt;
    f1_sq_r   <= f1_sq_nxt;
    // second stage: squared length
    f2_item_r.ang  <= f1_ang_r;
    f2_item_r.flip <= f1_flip_r;
    f2_item_r.zero <= f1_zero_r;
    f2_item_r.n2   <= f1_sq_r[0] + f1_sq_r[1] + f1_sq_r[2];
    f2_item_r.mag  <= f1_mag_r;
    f2_item_r.neg  <= f1_neg_r;
  end

  assign push      = f2_vld_r;
  assign push_item = f2_item_r;

endmodule

// File: src/aarm_queue.sv
module aarm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  aarm_pkg::aarm_item_t push_item,
  output logic                 pop,
  output aarm_pkg::aarm_item_t pop_item,
  output logic                 full
);
  import aarm_pkg::*;

  aarm_item_t  q_mem_r [2];
  logic        q_wr_r;
  logic        q_rd_r;
  logic [1:0]  q_cnt_r;

  // back end drains one item whenever one is queued
  assign pop      = (q_cnt_r != 2'd0);
  assign pop_item = q_mem_r[q_rd_r];
  assign full     = (q_cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wr_r <= ~q_wr_r;
      if (pop)  q_rd_r <= ~q_rd_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
    if (push) q_mem_r[q_wr_r] <= push_item;
  end

endmodule

// File: src/aarm_norm.sv
module aarm_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  aarm_pkg::aarm_item_t in_item,
  output logic                 out_valid,
  output aarm_pkg::aarm_rot_t  out_rot
);
  import aarm_pkg::*;

  localparam int ROOT_BITS = 32;
  localparam int QUO_BITS  = 32;

  // square root stages, one root bit each
  logic        sq_vld_in  [ROOT_BITS];
  aarm_item_t  sq_item_in [ROOT_BITS];
  logic [65:0] sq_rem_in  [ROOT_BITS];
  logic [31:0] sq_root_in [ROOT_BITS];
  logic [65:0] sq_trial   [ROOT_BITS];
  logic [65:0] sq_rem_nxt [ROOT_BITS];
  logic [31:0] sq_root_nxt[ROOT_BITS];
  logic        sq_vld_r   [ROOT_BITS];
  aarm_item_t  sq_item_r  [ROOT_BITS];
  logic [65:0] sq_rem_r   [ROOT_BITS];
  logic [31:0] sq_root_r  [ROOT_BITS];

  // division stages, one quotient bit each, three lanes
  logic        dv_vld_in  [QUO_BITS];
  aarm_item_t  dv_item_in [QUO_BITS];
  logic [31:0] dv_s_in    [QUO_BITS];
  logic [63:0] dv_rem_in  [QUO_BITS][3];
  logic [31:0] dv_q_in    [QUO_BITS][3];
  logic [63:0] dv_trial   [QUO_BITS];
  logic [63:0] dv_rem_nxt [QUO_BITS][3];
  logic [31:0] dv_q_nxt   [QUO_BITS][3];
  logic        dv_vld_r   [QUO_BITS];
  aarm_item_t  dv_item_r  [QUO_BITS];
  logic [31:0] dv_s_r     [QUO_BITS];
  logic [63:0] dv_rem_r   [QUO_BITS][3];
  logic [31:0] dv_q_r     [QUO_BITS][3];
  logic [31:0] q_cap      [3];

  // floor(sqrt(n2 * 2^32))
  always_comb begin
    sq_vld_in[0]  = in_valid;
    sq_item_in[0] = in_item;
    sq_rem_in[0]  = {2'b0, in_item.n2, 32'b0};
    sq_root_in[0] = '0;
    for (int k = 1; k < ROOT_BITS; k++) begin
      sq_vld_in[k]  = sq_vld_r[k-1];
      sq_item_in[k] = sq_item_r[k-1];
      sq_rem_in[k]  = sq_rem_r[k-1];
      sq_root_in[k] = sq_root_r[k-1];
    end
    for (int k = 0; k < ROOT_BITS; k++) begin
      sq_trial[k] = (66'(sq_root_in[k]) << (ROOT_BITS - k))
                  + (66'(1) << (2 * (ROOT_BITS - 1 - k)));
      if (sq_rem_in[k] >= sq_trial[k]) begin
        sq_rem_nxt[k]  = sq_rem_in[k] - sq_trial[k];
        sq_root_nxt[k] = sq_root_in[k] | (32'(1) << (ROOT_BITS - 1 - k));
      end else begin
        sq_rem_nxt[k]  = sq_rem_in[k];
        sq_root_nxt[k] = sq_root_in[k];
      end
    end
  end

  // (|a| * 2^46 + s/2) / s per component
  always_comb begin
    dv_vld_in[0]  = sq_vld_r[ROOT_BITS-1];
    dv_item_in[0] = sq_item_r[ROOT_BITS-1];
    dv_s_in[0]    = sq_root_r[ROOT_BITS-1];
    for (int j = 0; j < 3; j++) begin
      dv_rem_in[0][j] = (64'(sq_item_r[ROOT_BITS-1].mag[j]) << 46)
                      + 64'(sq_root_r[ROOT_BITS-1] >> 1);
      dv_q_in[0][j]   = '0;
    end
    for (int k = 1; k < QUO_BITS; k++) begin
      dv_vld_in[k]  = dv_vld_r[k-1];
      dv_item_in[k] = dv_item_r[k-1];
      dv_s_in[k]    = dv_s_r[k-1];
      for (int j = 0; j < 3; j++) begin
        dv_rem_in[k][j] = dv_rem_r[k-1][j];
        dv_q_in[k][j]   = dv_q_r[k-1][j];
      end
    end
    for (int k = 0; k < QUO_BITS; k++) begin
      dv_trial[k] = 64'(dv_s_in[k]) << (QUO_BITS - 1 - k);
      for (int j = 0; j < 3; j++) begin
        if (dv_rem_in[k][j] >= dv_trial[k]) begin
          dv_rem_nxt[k][j] = dv_rem_in[k][j] - dv_trial[k];
          dv_q_nxt[k][j]   = dv_q_in[k][j] | (32'(1) << (QUO_BITS - 1 - k));
        end else begin
          dv_rem_nxt[k][j] = dv_rem_in[k][j];
          dv_q_nxt[k][j]   = dv_q_in[k][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_BITS; k++) sq_vld_r[k] <= 1'b0;
      for (int k = 0; k < QUO_BITS; k++)  dv_vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < ROOT_BITS; k++) sq_vld_r[k] <= sq_vld_in[k];
      for (int k = 0; k < QUO_BITS; k++)  dv_vld_r[k] <= dv_vld_in[k];
    end
    for (int k = 0; k < ROOT_BITS; k++) begin
      sq_item_r[k] <= sq_item_in[k];
      sq_rem_r[k]  <= sq_rem_nxt[k];
      sq_root_r[k] <= sq_root_nxt[k];
    end
    for (int k = 0; k < QUO_BITS; k++) begin
      dv_item_r[k] <= dv_item_in[k];
      dv_s_r[k]    <= dv_s_in[k];
      for (int j = 0; j < 3; j++) begin
        dv_rem_r[k][j] <= dv_rem_nxt[k][j];
        dv_q_r[k][j]   <= dv_q_nxt[k][j];
      end
    end
  end

  // cap at one, restore sign
  always_comb begin
    out_valid    = dv_vld_r[QUO_BITS-1];
    out_rot.ang  = dv_item_r[QUO_BITS-1].ang;
    out_rot.flip = dv_item_r[QUO_BITS-1].flip;
    out_rot.zero = dv_item_r[QUO_BITS-1].zero;
    for (int j = 0; j < 3; j++) begin
      q_cap[j] = (dv_q_r[QUO_BITS-1][j] > 32'(Q30_ONE)) ? 32'(Q30_ONE)
                                                        : dv_q_r[QUO_BITS-1][j];
      out_rot.unit[j] = dv_item_r[QUO_BITS-1].neg[j] ? (~q_cap[j] + 32'd1) : q_cap[j];
    end
  end

endmodule

// File: src/aarm_cordic.sv
module aarm_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  aarm_pkg::aarm_rot_t in_rot,
  output logic                out_valid,
  output aarm_pkg::aarm_cs_t  out_cs
);
  import aarm_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic               cr_vld_in [NSTEP];
  aarm_rot_t          cr_rot_in [NSTEP];
  logic signed [33:0] cr_x_in   [NSTEP];
  logic signed [33:0] cr_y_in   [NSTEP];
  logic signed [33:0] cr_x_nxt  [NSTEP];
  logic signed [33:0] cr_y_nxt  [NSTEP];
  aarm_rot_t          cr_rot_nxt[NSTEP];
  logic               cr_vld_r  [NSTEP];
  aarm_rot_t          cr_rot_r  [NSTEP];
  logic signed [33:0] cr_x_r    [NSTEP];
  logic signed [33:0] cr_y_r    [NSTEP];

  // one rotation-mode micro-rotation per stage; z travels in rot.ang
  always_comb begin
    cr_vld_in[0] = in_valid;
    cr_rot_in[0] = in_rot;
    cr_x_in[0]   = Q30_GAIN;
    cr_y_in[0]   = '0;
    for (int i = 1; i < NSTEP; i++) begin
      cr_vld_in[i] = cr_vld_r[i-1];
      cr_rot_in[i] = cr_rot_r[i-1];
      cr_x_in[i]   = cr_x_r[i-1];
      cr_y_in[i]   = cr_y_r[i-1];
    end
    for (int i = 0; i < NSTEP; i++) begin
      cr_rot_nxt[i] = cr_rot_in[i];
      if (cr_rot_in[i].ang >= 0) begin
        cr_x_nxt[i]       = cr_x_in[i] - (cr_y_in[i] >>> i);
        cr_y_nxt[i]       = cr_y_in[i] + (cr_x_in[i] >>> i);
        cr_rot_nxt[i].ang = cr_rot_in[i].ang - $signed({3'b0, ATAN_Q30[i]});
      end else begin
        cr_x_nxt[i]       = cr_x_in[i] + (cr_y_in[i] >>> i);
        cr_y_nxt[i]       = cr_y_in[i] - (cr_x_in[i] >>> i);
        cr_rot_nxt[i].ang = cr_rot_in[i].ang + $signed({3'b0, ATAN_Q30[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTEP; i++) cr_vld_r[i] <= 1'b0;
    end else begin
      for (int i = 0; i < NSTEP; i++) cr_vld_r[i] <= cr_vld_in[i];
    end
    for (int i = 0; i < NSTEP; i++) begin
      cr_rot_r[i] <= cr_rot_nxt[i];
      cr_x_r[i]   <= cr_x_nxt[i];
      cr_y_r[i]   <= cr_y_nxt[i];
    end
  end

  // undo the fold by pi
  always_comb begin
    out_valid   = cr_vld_r[NSTEP-1];
    out_cs.c    = cr_rot_r[NSTEP-1].flip ? -cr_x_r[NSTEP-1] : cr_x_r[NSTEP-1];
    out_cs.s    = cr_rot_r[NSTEP-1].flip ? -cr_y_r[NSTEP-1] : cr_y_r[NSTEP-1];
    out_cs.zero = cr_rot_r[NSTEP-1].zero;
    out_cs.unit = cr_rot_r[NSTEP-1].unit;
  end

endmodule

// File: src/aarm_matrix.sv
module aarm_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  aarm_pkg::aarm_cs_t in_cs,
  output logic               out_valid,
  output logic [8:0][15:0]   out_entry,
  output logic               out_zero
);
  import aarm_pkg::*;

  logic                m1_vld_r, m2_vld_r, m3_vld_r, m4_vld_r, m5_vld_r;
  logic                m1_zero_r, m2_zero_r, m3_zero_r, m4_zero_r, m5_zero_r;
  logic signed [33:0]  m1_c_r, m2_c_r, m3_c_r;
  logic signed [65:0]  m1_p_r  [3];
  logic signed [65:0]  m1_su_r [3];
  logic signed [65:0]  m2_su_r [3];
  logic signed [65:0]  m3_su_r [3];
  logic signed [31:0]  m1_u_r  [3];
  logic signed [31:0]  m2_u_r  [3];
  logic signed [35:0]  m2_t_r  [3];
  logic signed [67:0]  m3_tu_r [3][3];
  logic signed [67:0]  m4_sum_r [9];
  logic signed [67:0]  m4_sum_nxt [9];
  logic [15:0]         m5_ent_r [9];
  logic [15:0]         m5_ent_nxt [9];
  logic signed [33:0]  d1;
  logic signed [67:0]  cq;
  logic signed [21:0]  rnd [9];

  assign d1 = Q30_ONE - in_cs.c;

  // entry sums in Q60
  always_comb begin
    cq = 68'(m3_c_r) <<< 30;
    m4_sum_nxt[0] = cq + m3_tu_r[0][0];
    m4_sum_nxt[1] = m3_tu_r[0][1] + 68'(m3_su_r[2]);
    m4_sum_nxt[2] = m3_tu_r[0][2] - 68'(m3_su_r[1]);
    m4_sum_nxt[3] = m3_tu_r[1][0] - 68'(m3_su_r[2]);
    m4_sum_nxt[4] = cq + m3_tu_r[1][1];
    m4_sum_nxt[5] = m3_tu_r[1][2] + 68'(m3_su_r[0]);
    m4_sum_nxt[6] = m3_tu_r[2][0] + 68'(m3_su_r[1]);
    m4_sum_nxt[7] = m3_tu_r[2][1] - 68'(m3_su_r[0]);
    m4_sum_nxt[8] = cq + m3_tu_r[2][2];
  end

  // round half up to Q14, saturate; identity for a zero axis
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      rnd[e] = 22'((m4_sum_r[e] + (68'sd1 <<< 45)) >>> 46);
      if (rnd[e] > 22'(Q14_ONE)) begin
        m5_ent_nxt[e] = Q14_ONE;
      end else if (rnd[e] < -22'(Q14_ONE)) begin
        m5_ent_nxt[e] = -Q14_ONE;
      end else begin
        m5_ent_nxt[e] = rnd[e][15:0];
      end
      if (m4_zero_r) begin
        m5_ent_nxt[e] = (e % 4 == 0) ? Q14_ONE : 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
      m5_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= in_valid;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
      m5_vld_r <= m4_vld_r;
    end
    m1_zero_r <= in_cs.zero;
    m2_zero_r <= m1_zero_r;
    m3_zero_r <= m2_zero_r;
    m4_zero_r <= m3_zero_r;
    m5_zero_r <= m4_zero_r;
    m1_c_r <= in_cs.c;
    m2_c_r <= m1_c_r;
    m3_c_r <= m2_c_r;
    for (int j = 0; j < 3; j++) begin
      // products (1-c)*u and s*u
      m1_p_r[j]  <= 66'(d1) * 66'($signed(in_cs.unit[j]));
      m1_su_r[j] <= 66'(in_cs.s) * 66'($signed(in_cs.unit[j]));
      m1_u_r[j]  <= $signed(in_cs.unit[j]);
      // t_k rounded to Q30
      m2_t_r[j]  <= 36'((m1_p_r[j] + 66'sd536870912) >>> 30);
      m2_u_r[j]  <= m1_u_r[j];
      m2_su_r[j] <= m1_su_r[j];
      m3_su_r[j] <= m2_su_r[j];
      // outer product t*u^T
      for (int k = 0; k < 3; k++) begin
        m3_tu_r[j][k] <= 68'(m2_t_r[j]) * 68'(m2_u_r[k]);
      end
    end
    for (int e = 0; e < 9; e++) begin
      m4_sum_r[e] <= m4_sum_nxt[e];
      m5_ent_r[e] <= m5_ent_nxt[e];
    end
  end

  always_comb begin
    out_valid = m5_vld_r;
    out_zero  = m5_zero_r;
    for (int e = 0; e < 9; e++) out_entry[e] = m5_ent_r[e];
  end

endmodule

// File: src/axis_angle_rotation_matrix_unit.sv
// Axis-angle to rotation matrix (Rodrigues form), fixed point.
//
// Input: pulse start with in_angle (Q2.13 radians) and the axis
// in_axis_x/y/z (any common scale). An item is taken on a clock edge
// with start high and busy low. busy is held low in normal use: the
// block takes one item every cycle.
// Output: out_valid is high for one cycle with the nine Q1.14 entries
// of the column-major 3x3 matrix and out_zero_axis (identity given for
// an all-zero axis). Results come out in input order.
// Pipeline: the 32-stage square root, the 32-stage divider for the unit
// axis, the CORDIC stages and the five-stage matrix multiply.
// Throughput: one item per clock.
// Reset (rst_n low, synchronous) drops all items in flight.
// The receiver cannot stall; each result is shown for exactly one cycle.
module axis_angle_rotation_matrix_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  output logic signed [15:0] out_col0_row0,
  output logic signed [15:0] out_col0_row1,
  output logic signed [15:0] out_col0_row2,
  output logic signed [15:0] out_col1_row0,
  output logic signed [15:0] out_col1_row1,
  output logic signed [15:0] out_col1_row2,
  output logic signed [15:0] out_col2_row0,
  output logic signed [15:0] out_col2_row1,
  output logic signed [15:0] out_col2_row2,
  output logic               out_zero_axis
);
  import aarm_pkg::*;

  logic             q_push, q_pop, q_full;
  aarm_item_t       q_push_item, q_pop_item;
  logic             nm_valid, cs_valid;
  aarm_rot_t        nm_rot;
  aarm_cs_t         cs_item;
  logic [8:0][15:0] entry;

  assign busy = q_full;

  // front end: accept and classify
  aarm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (start & ~busy),
    .in_angle  (in_angle),
    .in_axis_x (in_axis_x),
    .in_axis_y (in_axis_y),
    .in_axis_z (in_axis_z),
    .push      (q_push),
    .push_item (q_push_item)
  );

  aarm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .full      (q_full)
  );

  // back end: normalize, cos/sin, matrix
  aarm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_pop),
    .in_item   (q_pop_item),
    .out_valid (nm_valid),
    .out_rot   (nm_rot)
  );

  aarm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nm_valid),
    .in_rot    (nm_rot),
    .out_valid (cs_valid),
    .out_cs    (cs_item)
  );

  aarm_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cs_valid),
    .in_cs     (cs_item),
    .out_valid (out_valid),
    .out_entry (entry),
    .out_zero  (out_zero_axis)
  );

  assign out_col0_row0 = entry[0];
  assign out_col0_row1 = entry[1];
  assign out_col0_row2 = entry[2];
  assign out_col1_row0 = entry[3];
  assign out_col1_row1 = entry[4];
  assign out_col1_row2 = entry[5];
  assign out_col2_row0 = entry[6];
  assign out_col2_row1 = entry[7];
  assign out_col2_row2 = entry[8];

endmodule
